// File: hw/rtl/dtf_pkg.sv
// ----------------------------------------------------------------------------
// dtf_pkg - shared definitions for the decimal text to fixed-point converter
// Character codes, default sizes, the power-of-ten table and the job record
// passed from the character parser to the divider.
// ----------------------------------------------------------------------------
`default_nettype none

package dtf_pkg;

  localparam int DTF_FRAC_BITS       = 32;
  localparam int DTF_MAX_FRAC_DIGITS = 19;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

  // Accumulated number, handed over on the last character
  typedef struct packed {
    logic        negative;
    logic [63:0] mantissa;
    logic [4:0]  frac_count;
    logic        sat_flag;
  } dtf_job_t;

  // 10^k, k = 0..19
  function automatic logic [63:0] dtf_pow10(input logic [4:0] k);
    logic [63:0] p;
    case (k)
      5'd0:    p = 64'd1;
      5'd1:    p = 64'd10;
      5'd2:    p = 64'd100;
      5'd3:    p = 64'd1000;
      5'd4:    p = 64'd10000;
      5'd5:    p = 64'd100000;
      5'd6:    p = 64'd1000000;
      5'd7:    p = 64'd10000000;
      5'd8:    p = 64'd100000000;
      5'd9:    p = 64'd1000000000;
      5'd10:   p = 64'd10000000000;
      5'd11:   p = 64'd100000000000;
      5'd12:   p = 64'd1000000000000;
      5'd13:   p = 64'd10000000000000;
      5'd14:   p = 64'd100000000000000;
      5'd15:   p = 64'd1000000000000000;
      5'd16:   p = 64'd10000000000000000;
      5'd17:   p = 64'd100000000000000000;
      5'd18:   p = 64'd1000000000000000000;
      default: p = 64'd10000000000000000000;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/dtf_in_if.sv
// ----------------------------------------------------------------------------
// dtf_in_if - character stream channel
// One ASCII character per transfer, with a flag on the final one.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/dtf_out_if.sv
// ----------------------------------------------------------------------------
// dtf_out_if - fixed-point result channel
// One signed fixed-point value and its overflow flag per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtf_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] value;
  logic               overflow;

  modport source (output valid, output value, output overflow, input ready);
  modport sink   (input valid, input value, input overflow, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/dtf_parse.sv
// ----------------------------------------------------------------------------
// dtf_parse - character parser and digit accumulator
// Walks the number grammar one character per transfer and builds the
// mantissa, sign, fraction digit count and saturation flag.
// ----------------------------------------------------------------------------
`default_nettype none

module dtf_parse import dtf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] ch,
  input  logic       last,
  output dtf_job_t   job_next
);

  typedef enum logic [2:0] {
    PH_WS,
    PH_INT,
    PH_FRAC,
    PH_DROP,
    PH_DONE
  } phase_t;

  phase_t      phase, phase_next;
  dtf_job_t    job;

  logic        dig;
  logic        ws;
  logic [3:0]  d;
  logic [67:0] prod;
  logic        fits;

  assign dig  = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign ws   = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
  assign d    = ch[3:0];
  // mantissa * 10 + d, overflow shows in the top nibble
  assign prod = ({4'b0, job.mantissa} << 3) + ({4'b0, job.mantissa} << 1)
              + {64'b0, d};
  assign fits = (prod[67:64] == 4'b0);

  always_comb begin
    job_next   = job;
    phase_next = phase;
    unique case (phase)
      PH_WS: begin
        if (ws) begin
          phase_next = PH_WS;
        end else if (ch == CH_MINUS) begin
          job_next.negative = 1'b1;
          phase_next        = PH_INT;
        end else if (ch == CH_PLUS) begin
          phase_next = PH_INT;
        end else if (ch == CH_POINT) begin
          phase_next = PH_FRAC;
        end else if (dig) begin
          phase_next = PH_INT;
          if (fits) job_next.mantissa = prod[63:0];
          else      job_next.sat_flag = 1'b1;
        end else begin
          phase_next = PH_DONE;
        end
      end
      PH_INT: begin
        if (dig) begin
          if (!job.sat_flag) begin
            if (fits) job_next.mantissa = prod[63:0];
            else      job_next.sat_flag = 1'b1;
          end
        end else if (ch == CH_POINT) begin
          phase_next = PH_FRAC;
        end else begin
          phase_next = PH_DONE;
        end
      end
      PH_FRAC: begin
        if (dig) begin
          if ((job.frac_count >= 5'(DTF_MAX_FRAC_DIGITS)) || !fits) begin
            phase_next = PH_DROP;
          end else begin
            job_next.mantissa   = prod[63:0];
            job_next.frac_count = job.frac_count + 5'd1;
          end
        end else begin
          phase_next = PH_DONE;
        end
      end
      PH_DROP: begin
        if (!dig) phase_next = PH_DONE;
      end
      PH_DONE: phase_next = PH_DONE;
      default: phase_next = PH_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || (take && last)) begin
      phase <= PH_WS;
      job   <= '0;
    end else if (take) begin
      phase <= phase_next;
      job   <= job_next;
    end
  end

  a_frac_bound: assert property (@(posedge clk) disable iff (rst)
    job.frac_count <= 5'(DTF_MAX_FRAC_DIGITS))
    else $error("fraction digit count past its limit");

endmodule

`default_nettype wire

// File: hw/rtl/dtf_div.sv
// ----------------------------------------------------------------------------
// dtf_div - iterative scaler and result register
// Restoring division of mantissa * 2^FRAC_BITS by 10^frac_count, one
// quotient bit per cycle, then saturation, sign and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dtf_div import dtf_pkg::*; #(
  parameter int FRAC_BITS = DTF_FRAC_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  dtf_job_t         job,
  output logic             idle,
  dtf_out_if.source        res
);

  localparam int STEPS = 64 + FRAC_BITS;
  localparam int CW    = $clog2(STEPS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_t;

  state_t       state;
  logic [CW-1:0] cnt;
  logic [63:0]  num;
  logic [63:0]  p;
  logic [63:0]  r;
  logic [63:0]  q;
  logic         q_high;
  logic         negative;
  logic         sat_flag;

  logic [64:0]  rs;
  logic         ge;
  logic [64:0]  rdiff;
  logic [63:0]  limit;
  logic         ovf;
  logic [63:0]  mag;

  assign rs    = {r, num[63]};
  assign ge    = (rs >= {1'b0, p});
  assign rdiff = rs - {1'b0, p};

  assign limit = negative ? NEG_LIMIT : POS_LIMIT;
  assign ovf   = sat_flag || q_high || (q > limit);
  assign mag   = ovf ? limit : q;

  assign idle  = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      res.valid <= 1'b0;
    end else begin
      // in ST_FIN the load below decides valid
      if (res.valid && res.ready && (state != ST_FIN)) res.valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            num      <= job.mantissa;
            p        <= dtf_pow10(job.frac_count);
            r        <= '0;
            q        <= '0;
            q_high   <= 1'b0;
            negative <= job.negative;
            sat_flag <= job.sat_flag;
            cnt      <= '0;
            state    <= ST_RUN;
          end
        end
        ST_RUN: begin
          num    <= num << 1;
          r      <= ge ? rdiff[63:0] : rs[63:0];
          q      <= {q[62:0], ge};
          q_high <= q_high | q[63];
          cnt    <= cnt + 1'b1;
          if (cnt == CW'(STEPS - 1)) state <= ST_FIN;
        end
        ST_FIN: begin
          if (!res.valid || res.ready) begin
            res.valid    <= 1'b1;
            res.value    <= negative ? (64'd0 - mag) : mag;
            res.overflow <= ovf;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (r < p))
    else $error("remainder not below divisor");

  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    (idle && start) |=> (state == ST_RUN) && (cnt == '0))
    else $error("divider did not start");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (cnt <= CW'(STEPS - 1)))
    else $error("step counter past end");

  a_fin_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && !res.valid) |=> res.valid && (state == ST_IDLE))
    else $error("result not loaded into free output register");

endmodule

`default_nettype wire

// File: hw/rtl/decimal_text_to_fixed_point.sv
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_point - decimal text to signed fixed-point converter
//
// chars  : one ASCII character per transfer, last marks the end of a string.
//          Leading whitespace, an optional sign, integer digits, an optional
//          point and fraction digits are parsed; anything after the first
//          character outside that grammar is ignored up to last.
// result : one transfer per string, value = sign * floor(m * 2^FRAC_BITS /
//          10^digits) with FRAC_BITS fraction bits, saturated with overflow.
// Characters other than the last are taken whenever the divider is idle.
//   The last one starts the shared restoring divider, which makes one
//   quotient bit per cycle, 64 + FRAC_BITS bits in all, then saturates and
//   loads the output register; chars is not ready meanwhile.
// Stall: the result sits in the output register until taken; the next
//   string's characters are accepted meanwhile, and only a finished divide
//   waits for the register to free up.
// Reset: synchronous rst returns the parser to whitespace skipping, clears
//   the accumulator and drops any pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_text_to_fixed_point import dtf_pkg::*; #(
  parameter int FRAC_BITS = DTF_FRAC_BITS
) (
  input  logic       clk,
  input  logic       rst,
  dtf_in_if.sink     chars,
  dtf_out_if.source  result
);

  logic     take;
  logic     div_idle;
  dtf_job_t job_next;

  // Characters flow only while the divider is free
  assign chars.ready = div_idle;
  assign take        = chars.valid && chars.ready;

  dtf_parse u_parse (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .ch       (chars.ch),
    .last     (chars.last),
    .job_next (job_next)
  );

  // Last character: its parser update is folded into the job directly
  dtf_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (take && chars.last),
    .job   (job_next),
    .idle  (div_idle),
    .res   (result)
  );

endmodule

`default_nettype wire
